// ===== design/size_class_free_list_allocator_defines.svh =====
// Assertion helpers shared by the checker files.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SFLA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFLA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sfla_pkg.sv =====
`default_nettype none
package sfla_pkg;

  // Pool geometry
  localparam int NUM_CLASSES      = 128;
  localparam int BLOCKS_PER_CLASS = 128;
  localparam int TOTAL_BLOCKS     = NUM_CLASSES * BLOCKS_PER_CLASS;

  // Field widths
  localparam int SIZE_W     = 16;
  localparam int HANDLE_W   = 14;
  localparam int STATUS_W   = 2;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 16;

  // Size rounding grain of 8 bytes
  localparam int GRAIN_SHIFT = 3;
  localparam int KIDX_W      = SIZE_W + 1 - GRAIN_SHIFT;
  localparam logic [SIZE_W:0] GRAIN_MASK = (SIZE_W + 1)'((1 << GRAIN_SHIFT) - 1);

  // Storage widths
  localparam int BLK_AW  = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
  localparam int LINK_W  = $clog2(TOTAL_BLOCKS + 1);
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SLOT_W  = (BLOCKS_PER_CLASS > 1) ? $clog2(BLOCKS_PER_CLASS) : 1;
  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(TOTAL_BLOCKS);

  // Register indexes and reset values
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SIZE = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SIZE = CFG_ADDR_W'(1);
  localparam logic [SIZE_W-1:0]     MIN_SIZE_RST = SIZE_W'(16);
  localparam logic [SIZE_W-1:0]     MAX_SIZE_RST = SIZE_W'(1024);

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_NO_CLASS  = STATUS_W'(2);

  typedef struct packed {
    logic                req_type;
    logic [SIZE_W-1:0]   req_size;
    logic [HANDLE_W-1:0] free_handle;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] alloc_handle;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [CLS_W-1:0]  addr;
    logic [LINK_W-1:0] data;
  } head_wr_t;

  typedef struct packed {
    logic              en;
    logic [BLK_AW-1:0] addr;
    logic [LINK_W-1:0] data;
  } link_wr_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HEAD,
    S_LINK
  } state_t;

endpackage
`default_nettype wire

// ===== design/size_class_free_list_allocator.sv =====
`default_nettype none
// Size-class block allocator. A transaction is taken on a clock edge with start high and busy
// low; its result shows on rsp for exactly one cycle with done high and cannot be held off, so
// the receiver must take it then. Free, no-class and exhausted transactions finish in the
// head state; a granted allocate holds busy high there and then passes to the link state,
// as it needs the dependent reads of the class head memory and then the next-link memory,
// each with registered read data. After reset busy stays high while both memories are
// swept to their initial free lists; configuration writes are taken during that time.
module size_class_free_list_allocator
  import sfla_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire req_t                  req,
  output logic                       busy,
  output logic                       done,
  output rsp_t                       rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] min_size;
  logic [SIZE_W-1:0] max_size;
  logic              init_done;
  head_wr_t          init_head_wr, ctrl_head_wr, head_wr;
  link_wr_t          init_link_wr, ctrl_link_wr, link_wr;
  logic [CLS_W-1:0]  head_raddr;
  logic [BLK_AW-1:0] link_raddr;
  logic [LINK_W-1:0] head_rdata;
  logic [LINK_W-1:0] link_rdata;

  // Configuration registers; writes to unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      min_size <= MIN_SIZE_RST;
      max_size <= MAX_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MIN_SIZE: min_size <= SIZE_W'(cfg_data);
        REG_MAX_SIZE: max_size <= SIZE_W'(cfg_data);
        default: ;
      endcase
    end
  end

  sfla_init u_init (
    .clk       (clk),
    .rst       (rst),
    .init_done (init_done),
    .head_wr   (init_head_wr),
    .link_wr   (init_link_wr)
  );

  sfla_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .init_done  (init_done),
    .start      (start),
    .req        (req),
    .min_size   (min_size),
    .max_size   (max_size),
    .head_rdata (head_rdata),
    .link_rdata (link_rdata),
    .busy       (busy),
    .done       (done),
    .rsp        (rsp),
    .head_raddr (head_raddr),
    .link_raddr (link_raddr),
    .head_wr    (ctrl_head_wr),
    .link_wr    (ctrl_link_wr)
  );

  // Hand the write ports to the sweep until it finishes
  assign head_wr = init_done ? ctrl_head_wr : init_head_wr;
  assign link_wr = init_done ? ctrl_link_wr : init_link_wr;

  sfla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_CLASSES)
  ) u_head_ram (
    .clk   (clk),
    .we    (head_wr.en),
    .waddr (head_wr.addr),
    .wdata (head_wr.data),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  sfla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (TOTAL_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_wr.en),
    .waddr (link_wr.addr),
    .wdata (link_wr.data),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

endmodule
`default_nettype wire

// ===== design/sfla_ram.sv =====
`default_nettype none
module sfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/sfla_init.sv =====
`default_nettype none
module sfla_init
  import sfla_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  output logic      init_done,
  output head_wr_t  head_wr,
  output link_wr_t  link_wr
);

  logic              active;
  logic [BLK_AW-1:0] idx;
  logic [SLOT_W-1:0] slot;
  logic [CLS_W-1:0]  cls;
  logic [BLK_AW-1:0] idx_prev;
  logic              slot_last;

  assign idx_prev  = idx - BLK_AW'(1);
  assign slot_last = (slot == SLOT_W'(BLOCKS_PER_CLASS - 1));

  // Sweep every block once, tracking slot and class alongside the block index
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      idx    <= '0;
      slot   <= '0;
      cls    <= '0;
    end else if (active) begin
      if (idx == BLK_AW'(TOTAL_BLOCKS - 1)) begin
        active <= 1'b0;
      end
      idx <= idx + BLK_AW'(1);
      if (slot_last) begin
        slot <= '0;
        cls  <= cls + CLS_W'(1);
      end else begin
        slot <= slot + SLOT_W'(1);
      end
    end
  end

  // Link each slot to the previous one; the last slot becomes the class head
  always_comb begin
    link_wr.en   = active;
    link_wr.addr = idx;
    link_wr.data = (slot == '0) ? EMPTY_LINK : LINK_W'(idx_prev);
    head_wr.en   = active && slot_last;
    head_wr.addr = cls;
    head_wr.data = LINK_W'(idx);
  end

  assign init_done = !active;

endmodule
`default_nettype wire

// ===== design/sfla_ctrl.sv =====
`default_nettype none
module sfla_ctrl
  import sfla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              init_done,
  input  wire logic              start,
  input  wire req_t              req,
  input  wire logic [SIZE_W-1:0] min_size,
  input  wire logic [SIZE_W-1:0] max_size,
  input  wire logic [LINK_W-1:0] head_rdata,
  input  wire logic [LINK_W-1:0] link_rdata,
  output logic                   busy,
  output logic                   done,
  output rsp_t                   rsp,
  output logic [CLS_W-1:0]       head_raddr,
  output logic [BLK_AW-1:0]      link_raddr,
  output head_wr_t               head_wr,
  output link_wr_t               link_wr
);

  state_t              state, state_next;
  logic                cur_type;
  logic                cur_hit;
  logic [CLS_W-1:0]    cur_cls;
  logic [HANDLE_W-1:0] cur_handle;
  logic                fwd_valid;
  logic [LINK_W-1:0]   fwd_data;
  logic [LINK_W-1:0]   granted, granted_next;
  logic                done_next;
  rsp_t                rsp_next;

  logic [SIZE_W:0]     rounded;
  logic [SIZE_W:0]     diff;
  logic [KIDX_W-1:0]   kidx;
  logic                in_hit;
  logic [CLS_W-1:0]    in_cls;
  logic [LINK_W-1:0]   head_val;
  logic                head_empty;
  logic                handle_ok;
  logic                accept;
  logic                finish;

  // Map the request size to a class index
  always_comb begin
    rounded = ({1'b0, req.req_size} + GRAIN_MASK) & ~GRAIN_MASK;
    diff    = rounded - {1'b0, min_size};
    kidx    = diff[SIZE_W:GRAIN_SHIFT];
    in_hit  = !(rounded < {1'b0, min_size}) && !(rounded > {1'b0, max_size})
              && ((diff & GRAIN_MASK) == '0) && (kidx < KIDX_W'(NUM_CLASSES));
    in_cls  = CLS_W'(kidx);
  end

  assign head_raddr = in_cls;
  assign head_val   = fwd_valid ? fwd_data : head_rdata;
  assign head_empty = (32'(head_val) >= 32'(TOTAL_BLOCKS));
  assign handle_ok  = (32'(cur_handle) < 32'(TOTAL_BLOCKS));

  // Only a granted allocate needs the link-memory read; busy also holds during the reset sweep
  assign busy   = !init_done
                  || ((state == S_HEAD) && cur_hit && !cur_type && !head_empty);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Capture the transaction and forward a head written on the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_type   <= req.req_type;
      cur_hit    <= in_hit;
      cur_cls    <= in_cls;
      cur_handle <= req.free_handle;
      fwd_valid  <= head_wr.en && (head_wr.addr == in_cls);
      fwd_data   <= head_wr.data;
    end
    granted <= granted_next;
    if (done_next) begin
      rsp <= rsp_next;
    end
  end

  // Sequence the head read, the link read and the write-back
  always_comb begin
    state_next            = state;
    done_next             = 1'b0;
    rsp_next.status       = ST_DONE;
    rsp_next.alloc_handle = '0;
    head_wr               = '0;
    link_wr               = '0;
    link_raddr            = BLK_AW'(head_val);
    granted_next          = granted;
    finish                = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!cur_hit) begin
          rsp_next.status = ST_NO_CLASS;
          finish          = 1'b1;
        end else if (cur_type) begin
          // Push the freed handle in front of the current head
          if (handle_ok) begin
            link_wr.en   = 1'b1;
            link_wr.addr = BLK_AW'(cur_handle);
            link_wr.data = head_val;
            head_wr.en   = 1'b1;
            head_wr.addr = cur_cls;
            head_wr.data = LINK_W'(cur_handle);
          end
          finish = 1'b1;
        end else if (head_empty) begin
          rsp_next.status = ST_EXHAUSTED;
          finish          = 1'b1;
        end else begin
          granted_next = head_val;
          state_next   = S_LINK;
        end
      end
      S_LINK: begin
        // Pop: the next link becomes the new head
        head_wr.en            = 1'b1;
        head_wr.addr          = cur_cls;
        head_wr.data          = link_rdata;
        rsp_next.alloc_handle = HANDLE_W'(granted);
        finish                = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (finish) begin
      done_next  = 1'b1;
      state_next = accept ? S_HEAD : S_IDLE;
    end
  end

endmodule
`default_nettype wire

// ===== design/sfla_checker.sv =====
`default_nettype none
`include "size_class_free_list_allocator_defines.svh"
module sfla_checker
  import sfla_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire rsp_t rsp
);

  logic accept;
  assign accept = start && !busy;

  // Status codes stay in range
  `SFLA_ASSERT_IMP(a_status_code, done, (rsp.status == ST_DONE) || (rsp.status == ST_EXHAUSTED) || (rsp.status == ST_NO_CLASS), "status code out of range")

  // Failed transactions carry a zero handle
  `SFLA_ASSERT_IMP(a_fail_zero, done && (rsp.status != ST_DONE), rsp.alloc_handle == '0, "failed transaction returned a handle")

  // A transaction that frees the block right away reports on the next cycle
  `SFLA_ASSERT_NXT(a_short_done, accept ##1 !busy, done, "short transaction result missing")

  // A transaction that holds the block reports once it has passed through the link state
  `SFLA_ASSERT_NXT(a_long_done, accept ##1 busy, ##1 done, "allocate result missing")

  // No result without a transaction accepted earlier, by the short or the long path
  `SFLA_ASSERT_IMP(a_no_spurious, done, $past(accept, 2) || $past(accept, 3), "result without transaction")

endmodule

bind size_class_free_list_allocator sfla_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire

// ===== tb/tb_size_class_free_list_allocator.sv =====
`timescale 1ns / 100ps
module tb_size_class_free_list_allocator;
  import sfla_pkg::*;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = '1;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
  } live_blk_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  req_t                  req = '0;
  logic                  busy;
  logic                  done;
  rsp_t                  rsp;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the pool: list heads, links and the size window
  logic [LINK_W-1:0] head_model [NUM_CLASSES];
  logic [LINK_W-1:0] link_model [TOTAL_BLOCKS];
  logic [SIZE_W-1:0] min_model;
  logic [SIZE_W-1:0] max_model;

  rsp_t        awaited_rsp [$];
  live_blk_t   live_blocks [$];
  int unsigned hot_class [3];

  int burst_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int txn_count = 0;
  int grant_count = 0;
  int exhausted_count = 0;
  int no_class_count = 0;
  int free_count = 0;
  int settings_seen = 1;

  size_class_free_list_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req      (req),
    .busy     (busy),
    .done     (done),
    .rsp      (rsp),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Pool predictor
  // ---------------------------------------------------------------------------

  function automatic void init_free_lists();
    int c;
    int s;
    min_model = MIN_SIZE_RST;
    max_model = MAX_SIZE_RST;
    for (c = 0; c < NUM_CLASSES; c++) begin
      for (s = 0; s < BLOCKS_PER_CLASS; s++) begin
        link_model[c * BLOCKS_PER_CLASS + s] =
          (s == 0) ? EMPTY_LINK : LINK_W'(c * BLOCKS_PER_CLASS + s - 1);
      end
      head_model[c] = LINK_W'(c * BLOCKS_PER_CLASS + BLOCKS_PER_CLASS - 1);
    end
  endfunction

  function automatic void apply_register_write(logic [CFG_ADDR_W-1:0] idx,
                                               logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_MIN_SIZE: min_model = data;
      REG_MAX_SIZE: max_model = data;
      default: ;
    endcase
  endfunction

  // Round up to 8 bytes in 32-bit arithmetic, then map into the current size window
  function automatic bit size_to_class(input logic [SIZE_W-1:0] sz, output int unsigned k);
    int unsigned rounded;
    rounded = (32'(sz) + 7) & 32'hFFFF_FFF8;
    k = 0;
    if (rounded < 32'(min_model) || rounded > 32'(max_model)) return 1'b0;
    if (((rounded - 32'(min_model)) & 7) != 0) return 1'b0;
    k = (rounded - 32'(min_model)) / 8;
    if (k >= NUM_CLASSES) return 1'b0;
    return 1'b1;
  endfunction

  function automatic rsp_t pool_response(req_t r);
    rsp_t        o;
    int unsigned k;
    logic [LINK_W-1:0] head;
    o.status       = ST_DONE;
    o.alloc_handle = '0;
    if (!size_to_class(r.req_size, k)) begin
      o.status = ST_NO_CLASS;
    end else if (r.req_type == REQ_ALLOC) begin
      head = head_model[k];
      if (head >= TOTAL_BLOCKS) begin
        o.status = ST_EXHAUSTED;
      end else begin
        o.alloc_handle = head[HANDLE_W-1:0];
        head_model[k]  = link_model[head];
      end
    end else if (r.free_handle < TOTAL_BLOCKS) begin
      // push without any ownership check
      link_model[r.free_handle] = head_model[k];
      head_model[k] = LINK_W'(r.free_handle);
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic req_t make_req(logic t, logic [SIZE_W-1:0] sz, logic [HANDLE_W-1:0] h);
    req_t r;
    r.req_type    = t;
    r.req_size    = sz;
    r.free_handle = h;
    return r;
  endfunction

  function automatic int unsigned usable_classes();
    int unsigned n;
    if (min_model[2:0] != 3'd0 || min_model > max_model) return 0;
    n = (32'(max_model) - 32'(min_model)) / 8 + 1;
    return (n > NUM_CLASSES) ? NUM_CLASSES : n;
  endfunction

  // Any size that rounds up onto class k; assumes an aligned window
  function automatic logic [SIZE_W-1:0] size_for_class(int unsigned k);
    int unsigned base;
    int unsigned sub;
    base = 32'(min_model) + 8 * k;
    sub  = $urandom_range(0, 7);
    if (sub > base) sub = base;
    return SIZE_W'(base - sub);
  endfunction

  function automatic req_t pick_random_request();
    int unsigned n;
    int unsigned k;
    int unsigned roll;
    int unsigned idx;
    live_blk_t   b;
    logic [SIZE_W-1:0] sz;
    req_t r;
    n    = usable_classes();
    roll = $urandom_range(0, 99);
    k    = 0;
    if (n != 0) k = ($urandom_range(0, 9) < 7) ? hot_class[$urandom_range(0, 2)]
                                                : $urandom_range(0, n - 1);
    if (n == 0 || roll >= 88) begin
      // noise: arbitrary sizes and window edges
      case ($urandom_range(0, 3))
        0:       sz = SIZE_W'($urandom);
        1:       sz = min_model - 1'b1;
        2:       sz = max_model + 1'b1;
        default: sz = min_model + SIZE_W'(8 * NUM_CLASSES);
      endcase
      r = make_req(1'($urandom_range(0, 1)), sz, HANDLE_W'($urandom));
    end else if (roll < 45 || (roll < 80 && live_blocks.size() == 0)) begin
      r = make_req(REQ_ALLOC, size_for_class(k), HANDLE_W'($urandom));
    end else if (roll < 80) begin
      // return a granted block; now and then keep it to cause a double free
      idx = $urandom_range(0, live_blocks.size() - 1);
      b   = live_blocks[idx];
      if ($urandom_range(0, 19) != 0) live_blocks.delete(idx);
      r = make_req(REQ_FREE, b.size, b.handle);
    end else begin
      r = make_req(REQ_FREE, size_for_class(k), HANDLE_W'($urandom));
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Transaction driver
  // ---------------------------------------------------------------------------

  // Send one transaction in bursts with random gaps; predict on acceptance
  task automatic send_request(input req_t r, output rsp_t predicted);
    int unsigned gap;
    live_blk_t   b;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    predicted = pool_response(r);
    awaited_rsp.insert(awaited_rsp.size(), predicted);
    txn_count++;
    case (predicted.status)
      ST_EXHAUSTED: exhausted_count++;
      ST_NO_CLASS:  no_class_count++;
      default: begin
        if (r.req_type == REQ_FREE) begin
          free_count++;
        end else begin
          grant_count++;
          b.size   = r.req_size;
          b.handle = predicted.alloc_handle;
          live_blocks.insert(live_blocks.size(), b);
        end
      end
    endcase
  endtask

  task automatic issue(logic t, logic [SIZE_W-1:0] sz, logic [HANDLE_W-1:0] h);
    rsp_t ignored;
    send_request(make_req(t, sz, h), ignored);
  endtask

  // Stop sending, drain all results, then let the pipeline settle
  task automatic quiesce();
    start <= 1'b0;
    burst_left = 0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk);
    apply_register_write(idx, data);
  endtask

  task automatic reconfigure(logic [SIZE_W-1:0] lo, logic [SIZE_W-1:0] hi);
    quiesce();
    write_register(REG_MIN_SIZE, lo);
    write_register(REG_MAX_SIZE, hi);
    cfg_we <= 1'b0;
    live_blocks.delete();
    settings_seen++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, rsp_t want, rsp_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] %s: expected status %0d handle %0d, got status %0d handle %0d",
               $realtime, what, want.status, want.alloc_handle, got.status, got.alloc_handle);
  endtask

  // Compare each strobed result with the oldest prediction
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && done) begin
      if (awaited_rsp.size() == 0) begin
        report_mismatch("unexpected result", '0, rsp);
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.status !== want.status || rsp.alloc_handle !== want.alloc_handle)
          report_mismatch("result mismatch", want, rsp);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, rounding, unchecked handles and double free at reset window
  task automatic test_directed_defaults();
    issue(REQ_ALLOC, 16, 0);
    issue(REQ_ALLOC, 9, '1);
    issue(REQ_ALLOC, 1024, 0);
    issue(REQ_ALLOC, 1017, 0);
    issue(REQ_ALLOC, 8, 0);
    issue(REQ_ALLOC, 0, 0);
    issue(REQ_ALLOC, 1025, 0);
    issue(REQ_ALLOC, 16'hFFFF, 0);
    issue(REQ_FREE, 16, 127);
    issue(REQ_ALLOC, 16, 0);
    issue(REQ_FREE, 2000, 5);
    issue(REQ_FREE, 24, 16255);
    issue(REQ_ALLOC, 24, 0);
    issue(REQ_FREE, 32, 300);
    issue(REQ_FREE, 32, 300);
    issue(REQ_ALLOC, 32, 0);
    issue(REQ_ALLOC, 32, 0);
    issue(REQ_FREE, 40, 0);
    issue(REQ_FREE, 40, '1);
    issue(REQ_ALLOC, 40, 0);
    issue(REQ_ALLOC, 40, 0);
  endtask

  // Empty one class, run past exhaustion, refill part of it and take again
  task automatic test_class_drain();
    int unsigned k;
    int unsigned idx;
    int i;
    rsp_t got;
    logic [HANDLE_W-1:0] held [$];
    k = $urandom_range(8, 120);
    for (i = 0; i < BLOCKS_PER_CLASS + 3; i++) begin
      send_request(make_req(REQ_ALLOC, size_for_class(k), HANDLE_W'($urandom)), got);
      if (got.status == ST_DONE) held.insert(held.size(), got.alloc_handle);
    end
    for (i = 0; i < 40 && held.size() != 0; i++) begin
      idx = $urandom_range(0, held.size() - 1);
      issue(REQ_FREE, size_for_class(k), held[idx]);
      held.delete(idx);
    end
    for (i = 0; i < 10; i++) issue(REQ_ALLOC, size_for_class(k), HANDLE_W'($urandom));
  endtask

  // Size window extremes, unaligned and inverted windows, unknown registers
  task automatic test_size_window();
    reconfigure(16'd0, 16'hFFFF);
    issue(REQ_ALLOC, 0, 0);
    issue(REQ_ALLOC, 1016, 0);
    issue(REQ_ALLOC, 1017, 0);
    issue(REQ_FREE, 0, HANDLE_W'($urandom));
    reconfigure(16'd65528, 16'hFFFF);
    issue(REQ_ALLOC, 65528, 0);
    issue(REQ_ALLOC, 65521, 0);
    issue(REQ_ALLOC, 65529, 0);
    issue(REQ_ALLOC, 16'hFFFF, 0);
    reconfigure(16'd13, 16'd1024);
    issue(REQ_ALLOC, 13, 0);
    issue(REQ_ALLOC, 21, 0);
    reconfigure(16'd512, 16'd256);
    issue(REQ_ALLOC, 300, 0);
    issue(REQ_FREE, 512, 7);
    reconfigure(16'd0, 16'd0);
    issue(REQ_ALLOC, 0, 0);
    issue(REQ_ALLOC, 1, 0);
    // writes to indexes past the register list must leave the window alone
    quiesce();
    write_register(REG_SPARE_LO, 16'hFFFF);
    write_register(REG_SPARE_HI, 16'h0008);
    cfg_we <= 1'b0;
    issue(REQ_ALLOC, 0, 0);
    issue(REQ_ALLOC, 8, 0);
  endtask

  task automatic run_traffic_phase(logic [SIZE_W-1:0] lo, logic [SIZE_W-1:0] hi, int count);
    int i;
    int unsigned n;
    rsp_t ignored;
    reconfigure(lo, hi);
    n = usable_classes();
    for (i = 0; i < 3; i++) hot_class[i] = (n == 0) ? 0 : $urandom_range(0, n - 1);
    for (i = 0; i < count; i++) send_request(pick_random_request(), ignored);
  endtask

  // Mostly alloc/free pairs on a few busy classes, with noise, over several windows
  task automatic test_random_traffic();
    int unsigned lo;
    lo = $urandom_range(0, 4000) * 8;
    run_traffic_phase(16'd16, 16'd1024, 300);
    run_traffic_phase(16'd0, 16'hFFFF, 240);
    run_traffic_phase(16'd65024, 16'hFFFF, 180);
    run_traffic_phase(SIZE_W'(lo), SIZE_W'(lo + $urandom_range(0, 1500)), 180);
    run_traffic_phase(16'd8, 16'd8, 150);
  endtask

  initial begin
    init_free_lists();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_defaults();
    test_class_drain();
    test_size_window();
    test_random_traffic();
    quiesce();
    $display("Ran %0d transactions over %0d size windows", txn_count, settings_seen);
    $display("  grants %0d, frees %0d, exhausted %0d, no class %0d, mismatches %0d",
             grant_count, free_count, exhausted_count, no_class_count, mismatch_count);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
